### hw/rtl/mtp_pkg.sv
// Shared types and constants of the MT19937 generator.
package mtp_pkg;

  localparam int unsigned MtWords = 624;
  localparam int unsigned MtShift = 397;
  localparam int unsigned IdxW    = 10;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [31:0]     word_t;

  localparam word_t MtMatrix      = 32'h9908_b0df;
  localparam word_t MtUpper       = 32'h8000_0000;
  localparam word_t MtLower       = 32'h7fff_ffff;
  localparam word_t MtMult        = 32'd1812433253;
  localparam word_t MtTemperB     = 32'h9d2c_5680;
  localparam word_t MtTemperC     = 32'hefc6_0000;
  localparam word_t MtDefaultSeed = 32'd5489;

  localparam logic OpGenerate = 1'b0;
  localparam logic OpSeed     = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSeedMul,
    StSeedAdd,
    StGenRd,
    StGenFar,
    StGenWb
  } state_e;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr_a;
    idx_t addr_b;
  } mem_rd_t;

endpackage

### hw/rtl/mersenne_twister_prng.sv
// MT19937 generator top level: sequencer, seeding, on-the-fly twist and tempering.
//
//  channel  | dir | tdata              | tuser
//  s_axis   | in  | [31:0] seed_value  | [0] operation (0 generate, 1 seed)
//  m_axis   | out | [31:0] random_word | -
//
// Generate: each word passes accept, far-word read, and twist and write back, in order,
// set by the single state memory and its registered read data; no new request is taken meanwhile.
// Seed: the accept writes word 0, then one multiply and one add per remaining state word.
// First generate without a prior seed: seeding with 5489, then a word read and the generate steps.
// Reset leaves the memory untouched and marks the generator unseeded.
// A waiting result stalls only the write-back of the following word.
module mersenne_twister_prng import mtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] random_word
);

  state_e  state_q, state_d;
  mem_wr_t wr;
  mem_rd_t rd;
  word_t   rd_a, rd_b;

  logic    seeded_q;
  logic    pend_q;
  idx_t    idx_q;
  idx_t    cnt_q;
  word_t   prev_q;
  word_t   prod_q;
  word_t   y_q;
  logic    out_valid_q;
  word_t   out_data_q;

  logic    s_fire;
  logic    gen_adv;
  word_t   prev_x;
  word_t   mul_d;
  word_t   twisted;

  function automatic idx_t next_idx(idx_t k);
    return (k == idx_t'(MtWords - 1)) ? '0 : idx_t'(k + 1'b1);
  endfunction

  function automatic idx_t far_idx(idx_t k);
    return (k < idx_t'(MtWords - MtShift)) ? idx_t'(k + idx_t'(MtShift))
                                           : idx_t'(k - idx_t'(MtWords - MtShift));
  endfunction

  function automatic word_t temper(word_t v);
    word_t t;
    t = v;
    t = t ^ (t >> 11);
    t = t ^ ((t << 7) & MtTemperB);
    t = t ^ ((t << 15) & MtTemperC);
    t = t ^ (t >> 18);
    return t;
  endfunction

  assign s_fire  = s_axis_tvalid & s_axis_tready;
  assign prev_x  = prev_q ^ (prev_q >> 30);
  assign mul_d   = prev_x * MtMult;
  assign twisted = rd_a ^ (y_q >> 1) ^ (y_q[0] ? MtMatrix : '0);

  mtp_state_ram u_ram (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .rd_i   (rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_fire) begin
          if (s_axis_tuser == OpSeed || !seeded_q) begin
            state_d = StSeedMul;
          end else begin
            state_d = StGenFar;
          end
        end
      end
      StSeedMul: state_d = StSeedAdd;
      StSeedAdd: begin
        if (cnt_q == idx_t'(MtWords - 1)) begin
          state_d = pend_q ? StGenRd : StIdle;
        end else begin
          state_d = StSeedMul;
        end
      end
      StGenRd:  state_d = StGenFar;
      StGenFar: state_d = StGenWb;
      StGenWb: begin
        if (gen_adv) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    gen_adv       = 1'b0;
    wr            = '0;
    rd            = '0;
    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_fire) begin
          if (s_axis_tuser == OpSeed) begin
            wr.en   = 1'b1;
            wr.data = s_axis_tdata;
          end else if (seeded_q) begin
            rd.en     = 1'b1;
            rd.addr_a = idx_q;
            rd.addr_b = next_idx(idx_q);
          end else begin
            wr.en   = 1'b1;
            wr.data = MtDefaultSeed;
          end
        end
      end
      StSeedAdd: begin
        wr.en   = 1'b1;
        wr.addr = cnt_q;
        wr.data = prod_q + word_t'(cnt_q);
      end
      StGenRd: begin
        rd.en     = 1'b1;
        rd.addr_a = idx_q;
        rd.addr_b = next_idx(idx_q);
      end
      StGenFar: begin
        rd.en     = 1'b1;
        rd.addr_a = far_idx(idx_q);
        rd.addr_b = idx_q;
      end
      StGenWb: begin
        if (!out_valid_q || m_axis_tready) begin
          gen_adv = 1'b1;
          wr.en   = 1'b1;
          wr.addr = idx_q;
          wr.data = twisted;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seeded_q    <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && s_fire && (s_axis_tuser == OpSeed || !seeded_q)) begin
        seeded_q <= 1'b1;
        pend_q   <= (s_axis_tuser == OpGenerate);
        idx_q    <= '0;
        cnt_q    <= idx_t'(1);
      end
      if (state_q == StSeedAdd) begin
        cnt_q <= idx_t'(cnt_q + 1'b1);
      end
      if (state_q == StGenRd) begin
        pend_q <= 1'b0;
      end
      if (gen_adv) begin
        idx_q       <= next_idx(idx_q);
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_fire) begin
      prev_q <= (s_axis_tuser == OpSeed) ? s_axis_tdata : MtDefaultSeed;
    end else if (state_q == StSeedAdd) begin
      prev_q <= wr.data;
    end
    if (state_q == StSeedMul) begin
      prod_q <= mul_d;
    end
    if (state_q == StGenFar) begin
      y_q <= (rd_a & MtUpper) | (rd_b & MtLower);
    end
    if (gen_adv) begin
      out_data_q <= temper(twisted);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr.en && rd.en))
    else $error("state memory read and write in the same cycle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < idx_t'(MtWords))
    else $error("word index out of range");

  a_seed_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSeedMul || state_q == StSeedAdd) |->
      (cnt_q != '0 && cnt_q < idx_t'(MtWords)))
    else $error("seed counter out of range");

  a_gen_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_adv |-> (seeded_q && !pend_q))
    else $error("word produced from unseeded state");
`endif

endmodule

### hw/rtl/mtp_state_ram.sv
// State word memory: one write port, two read ports, registered read data.
module mtp_state_ram import mtp_pkg::*; (
  input  logic    clk_i,
  input  mem_wr_t wr_i,
  input  mem_rd_t rd_i,
  output word_t   rd_a_o,
  output word_t   rd_b_o
);

  word_t mem_q [MtWords];
  word_t rd_a_q;
  word_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_a_q <= mem_q[rd_i.addr_a];
      rd_b_q <= mem_q[rd_i.addr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### bench/mersenne_twister_prng_test.sv
// Self-checking testbench of the MT19937 generator: directed rows, random seed and draw streams.
module mersenne_twister_prng_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  localparam int unsigned Unseeded      = MtWords + 1;
  localparam int unsigned ItemTarget    = 1350;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned SettleCycles  = 1300;
  localparam int unsigned OpeningCount  = 20;
  localparam word_t       FirstDefault  = 32'hd091_bb5c;

  typedef struct packed {
    logic  op;
    word_t seed;
    logic  has_word;
    word_t word;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;     // [31:0] seed_value
  logic        s_axis_tuser = OpGenerate; // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] random_word

  word_t       mt_state [MtWords];
  int unsigned mt_index = Unseeded;
  word_t       expected_words [$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          long_hold_done = 1'b0;

  stim_row_t opening_items [OpeningCount] = '{
    '{OpGenerate, 32'h0000_0000, 1'b1, FirstDefault},
    '{OpGenerate, 32'hffff_ffff, 1'b0, 32'h0},
    '{OpGenerate, 32'ha5a5_a5a5, 1'b0, 32'h0},
    '{OpSeed,     32'h0000_0000, 1'b0, 32'h0},
    '{OpGenerate, 32'h0000_0000, 1'b0, 32'h0},
    '{OpGenerate, 32'hffff_ffff, 1'b0, 32'h0},
    '{OpSeed,     32'hffff_ffff, 1'b0, 32'h0},
    '{OpGenerate, 32'h0000_0000, 1'b0, 32'h0},
    '{OpSeed,     MtDefaultSeed, 1'b0, 32'h0},
    '{OpGenerate, 32'h0000_0000, 1'b1, FirstDefault},
    '{OpGenerate, 32'h0000_0000, 1'b0, 32'h0},
    '{OpSeed,     32'h0000_0001, 1'b0, 32'h0},
    '{OpGenerate, 32'h0000_0000, 1'b0, 32'h0},
    '{OpSeed,     32'h8000_0000, 1'b0, 32'h0},
    '{OpGenerate, 32'h0000_0000, 1'b0, 32'h0},
    '{OpSeed,     32'h7fff_ffff, 1'b0, 32'h0},
    '{OpSeed,     32'h1234_5678, 1'b0, 32'h0},
    '{OpGenerate, 32'h0000_0000, 1'b0, 32'h0},
    '{OpGenerate, 32'h5a5a_5a5a, 1'b0, 32'h0},
    '{OpGenerate, 32'h0000_0000, 1'b0, 32'h0}
  };

  mersenne_twister_prng uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void fill_from_seed(word_t seed);
    mt_state[0] = seed;
    for (int unsigned i = 1; i < MtWords; i++) begin
      mt_state[i] = MtMult * (mt_state[i-1] ^ (mt_state[i-1] >> 30)) + word_t'(i);
    end
    mt_index = MtWords;
  endfunction

  function automatic void twist_all_words();
    word_t mix;
    for (int unsigned k = 0; k < MtWords; k++) begin
      mix = (mt_state[k] & MtUpper) | (mt_state[(k + 1) % MtWords] & MtLower);
      mt_state[k] = mt_state[(k + MtShift) % MtWords] ^ (mix >> 1) ^
                    (mix[0] ? MtMatrix : word_t'(0));
    end
    mt_index = 0;
  endfunction

  function automatic word_t temper_word(word_t w);
    w ^= w >> 11;
    w ^= (w << 7) & MtTemperB;
    w ^= (w << 15) & MtTemperC;
    w ^= w >> 18;
    return w;
  endfunction

  function automatic word_t next_random_word();
    word_t picked;
    if (mt_index >= MtWords) begin
      if (mt_index == Unseeded) fill_from_seed(MtDefaultSeed);
      twist_all_words();
    end
    picked = mt_state[mt_index];
    mt_index++;
    return temper_word(picked);
  endfunction

  task automatic offer_item(logic op, word_t seed, logic has_word, word_t word);
    word_t predicted;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= seed;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    items_sent++;
    if (op == OpSeed) begin
      fill_from_seed(seed);
    end else begin
      predicted = next_random_word();
      expected_words.push_back(has_word ? word : predicted);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  initial begin : source
    int unsigned run_len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening_items[i]) begin
      offer_item(opening_items[i].op, opening_items[i].seed,
                 opening_items[i].has_word, opening_items[i].word);
    end
    drain_results();
    offer_item(OpSeed, $urandom(), 1'b0, '0);
    run_len = $urandom_range(630, 700);
    repeat (run_len) offer_item(OpGenerate, $urandom(), 1'b0, '0);
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) offer_item(OpSeed, $urandom(), 1'b0, '0);
      else offer_item(OpGenerate, $urandom(), 1'b0, '0);
    end
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("mersenne_twister_prng test passed");
    end else begin
      $display("mersenne_twister_prng test failed");
    end
    $finish;
  end

  initial begin : sink
    int unsigned mode;
    int unsigned span;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        $error("random_word: expected no transaction, actual %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata !== want) begin
          $error("random_word: expected %h, actual %h", want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("mersenne_twister_prng test failed");
      $finish;
    end
  end

endmodule

### mersenne_twister_prng.f
hw/rtl/mtp_pkg.sv
hw/rtl/mtp_state_ram.sv
hw/rtl/mersenne_twister_prng.sv
bench/mersenne_twister_prng_test.sv
